// File: design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define KLR_ASSERT(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define KLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KLR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/klr_pkg.sv
// shared types, constants and layout functions of the ripple renderer
`default_nettype none
package klr_pkg;

    localparam int BAND_COUNT  = 5;
    localparam int EMIT_MAX    = 64;
    localparam int KEY_W       = 7;
    localparam int AGE_W       = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [4:0] START_PHASE = -5'sd10;

    // strip position where each band starts
    localparam logic [6:0] BAND_BASE [BAND_COUNT] = '{7'd0, 7'd14, 7'd28, 7'd41, 7'd53};

    typedef logic [1:0] t_kind;
    localparam t_kind CMD_PRESS  = 2'd0;
    localparam t_kind CMD_RENDER = 2'd1;
    localparam t_kind CMD_EMIT   = 2'd2;

    typedef struct packed {
        t_kind            kind;
        logic [KEY_W-1:0] key_index;
    } t_cmd;

    typedef struct packed {
        logic red;
        logic green;
        logic blue;
    } t_chan_en;

    localparam logic [1:0] REG_RED    = 2'd0;
    localparam logic [1:0] REG_GREEN  = 2'd1;
    localparam logic [1:0] REG_BLUE   = 2'd2;
    localparam logic [1:0] REG_RIPPLE = 2'd3;

    // last band whose start the index reaches
    function automatic logic [2:0] band_of(input logic [6:0] idx);
        logic [2:0] b;
        priority if (idx >= BAND_BASE[4]) b = 3'd4;
        else if (idx >= BAND_BASE[3]) b = 3'd3;
        else if (idx >= BAND_BASE[2]) b = 3'd2;
        else if (idx >= BAND_BASE[1]) b = 3'd1;
        else b = 3'd0;
        return b;
    endfunction

endpackage
`default_nettype wire

// File: design/klr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module klr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: design/klr_front.sv
// request decode: key index, scan phase and command classification
`default_nettype none
module klr_front import klr_pkg::*; #(
    parameter int ROW_STRIDE = 12
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic       i_operation,
    input  wire logic [2:0] i_key_column,
    input  wire logic [3:0] i_key_row,
    input  wire logic       i_ripple_en,
    output logic            o_push,
    output t_cmd            o_cmd
);
    logic signed [4:0] r_phase, n_phase;
    logic [9:0]        key_sum;

    assign key_sum = 10'(i_key_column) * 10'(ROW_STRIDE) + 10'(i_key_row);

    always_comb begin
        n_phase         = r_phase;
        o_push          = 1'b0;
        o_cmd.kind      = CMD_PRESS;
        o_cmd.key_index = key_sum[KEY_W-1:0];
        if (i_accept) begin
            if (!i_operation) begin
                o_push = 1'b1;
            end else if (i_ripple_en) begin
                if (r_phase == 5'sd0) begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_RENDER;
                end else if (r_phase == 5'sd1) begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_EMIT;
                end
                n_phase = (r_phase == 5'sd1) ? 5'sd0 : r_phase + 5'sd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= START_PHASE;
        end else begin
            r_phase <= n_phase;
        end
    end
endmodule
`default_nettype wire

// File: design/klr_cmd_fifo.sv
// short command queue between decode and render engine
`default_nettype none
`include "assert_macros.svh"
module klr_cmd_fifo import klr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output logic      o_vld,
    output t_cmd      o_cmd,
    output logic      o_full
);
    localparam int QW = $clog2(QUEUE_DEPTH);

    t_cmd            r_mem [QUEUE_DEPTH];
    logic [QW-1:0]   r_wp, r_rp;
    logic [QW:0]     r_cnt;

    assign o_vld  = (r_cnt != '0);
    assign o_full = (r_cnt == (QW+1)'(QUEUE_DEPTH));
    assign o_cmd  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QW+1)'(i_push) - (QW+1)'(i_pop);
        end
    end

    `KLR_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `KLR_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_vld, "pop from empty queue")
endmodule
`default_nettype wire

// File: design/klr_back.sv
// render engine: source ring, color store, render and emit sweeps
`default_nettype none
`include "assert_macros.svh"
module klr_back import klr_pkg::*; #(
    parameter int RING_DEPTH = 32,
    parameter int MAX_AGE    = 64,
    parameter int LED_COUNT  = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_vld,
    input  wire t_cmd       i_cmd,
    output logic            o_cmd_pop,
    input  wire t_chan_en   i_en,
    output logic            o_valid,
    output logic [5:0]      o_led_index,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic            o_last
);
    localparam int RW    = $clog2(RING_DEPTH);
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int LED_N = (LED_COUNT < EMIT_MAX) ? LED_COUNT : EMIT_MAX;
    localparam int LW    = (LED_N > 1) ? $clog2(LED_N) : 1;
    localparam int SW    = KEY_W + AGE_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SRC_RD = 3'd1;
    localparam logic [2:0] S_SRC_LD = 3'd2;
    localparam logic [2:0] S_SWEEP  = 3'd3;
    localparam logic [2:0] S_AGE    = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [RW-1:0]    r_head, n_head, r_tail, n_tail, r_ptr, n_ptr;
    logic [CW-1:0]    r_count, n_count, r_k, n_k, r_n, n_n;
    logic [LW-1:0]    r_led, n_led;
    logic [LED_N-1:0] r_vld, n_vld;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AGE_W-1:0] r_age, n_age;
    logic [2:0]       r_band, n_band;
    logic [6:0]       r_pos, n_pos;

    logic             r_p1_vld, n_p1_vld;
    logic [LW-1:0]    r_p1_led;
    logic [5:0]       r_p1_e, n_p1_e;
    logic             r_e1_vld, n_e1_vld;
    logic [LW-1:0]    r_e1_led;

    logic             src_we;
    logic [RW-1:0]    src_waddr;
    logic [SW-1:0]    src_wdata, src_rdata;
    logic [23:0]      st_rdata, st_wdata, cur;

    logic [2:0]       led_y, dy, ld_band;
    logic [6:0]       led_x, dx;
    logic [7:0]       span;
    logic signed [8:0] diff;
    logic             hit;

    function automatic logic [RW-1:0] ring_inc(input logic [RW-1:0] p);
        return (p == RW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [5:0] e);
        logic [8:0] s;
        s = 9'(v) + 9'(e);
        return s[8] ? 8'hFF : s[7:0];
    endfunction

    klr_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_src_ram (
        .i_clk  (i_clk),
        .i_we   (src_we),
        .i_waddr(src_waddr),
        .i_wdata(src_wdata),
        .i_raddr(r_ptr),
        .o_rdata(src_rdata)
    );

    klr_ram #(.WIDTH(24), .DEPTH(LED_N)) u_store_ram (
        .i_clk  (i_clk),
        .i_we   (r_p1_vld),
        .i_waddr(r_p1_led),
        .i_wdata(st_wdata),
        .i_raddr(r_led),
        .o_rdata(st_rdata)
    );

    // elevation of the led under the sweep counter for the loaded source
    assign led_y = band_of(7'(r_led));
    assign led_x = 7'(r_led) - BAND_BASE[led_y];
    assign dx    = (led_x >= r_pos) ? led_x - r_pos : r_pos - led_x;
    assign dy    = (led_y >= r_band) ? led_y - r_band : r_band - led_y;
    assign span  = 8'(dx) + 8'(dy);
    assign diff  = $signed({2'b00, r_age}) - $signed({1'b0, span});
    assign hit   = !diff[8] && (diff[7:3] == 5'd0);

    assign ld_band = band_of(src_rdata[SW-1:AGE_W]);

    // entries not written since the last render read as zero
    assign cur = r_vld[r_p1_led] ? st_rdata : '0;
    assign st_wdata = {i_en.red   ? sat_add(cur[23:16], r_p1_e) : cur[23:16],
                       i_en.green ? sat_add(cur[15:8],  r_p1_e) : cur[15:8],
                       i_en.blue  ? sat_add(cur[7:0],   r_p1_e) : cur[7:0]};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_k       = r_k;
        n_n       = r_n;
        n_led     = r_led;
        n_vld     = r_vld;
        n_key     = r_key;
        n_age     = r_age;
        n_band    = r_band;
        n_pos     = r_pos;
        n_p1_vld  = 1'b0;
        n_p1_e    = '0;
        n_e1_vld  = 1'b0;
        o_cmd_pop = 1'b0;
        src_we    = 1'b0;
        src_waddr = r_tail;
        src_wdata = {i_cmd.key_index, AGE_W'(0)};
        if (r_p1_vld) begin
            n_vld[r_p1_led] = 1'b1;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_PRESS: begin
                            // full ring drops its oldest source
                            src_we = 1'b1;
                            n_tail = ring_inc(r_tail);
                            if (r_count == CW'(RING_DEPTH)) begin
                                n_head = ring_inc(r_head);
                            end else begin
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_RENDER: begin
                            n_vld = '0;
                            n_ptr = r_head;
                            n_k   = '0;
                            n_n   = r_count;
                            if (r_count != '0) n_state = S_SRC_RD;
                        end
                        CMD_EMIT: begin
                            n_led   = '0;
                            n_state = S_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SRC_RD: n_state = S_SRC_LD;
            S_SRC_LD: begin
                n_key   = src_rdata[SW-1:AGE_W];
                n_age   = src_rdata[AGE_W-1:0];
                n_band  = ld_band;
                n_pos   = src_rdata[SW-1:AGE_W] - BAND_BASE[ld_band];
                n_led   = '0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_p1_vld = 1'b1;
                n_p1_e   = hit ? {4'd8 - {1'b0, diff[2:0]}, 2'b00} : 6'd0;
                n_led    = r_led + 1'b1;
                if (r_led == LW'(LED_N - 1)) n_state = S_AGE;
            end
            S_AGE: begin
                if (r_age < AGE_W'(MAX_AGE)) begin
                    src_we    = 1'b1;
                    src_waddr = r_ptr;
                    src_wdata = {r_key, r_age + 1'b1};
                end else begin
                    n_head  = ring_inc(r_head);
                    n_count = r_count - 1'b1;
                end
                n_ptr   = ring_inc(r_ptr);
                n_k     = r_k + 1'b1;
                n_state = (r_k + 1'b1 == r_n) ? S_IDLE : S_SRC_RD;
            end
            S_EMIT: begin
                n_e1_vld = 1'b1;
                n_led    = r_led + 1'b1;
                if (r_led == LW'(LED_N - 1)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr       <= n_ptr;
        r_k         <= n_k;
        r_n         <= n_n;
        r_led       <= n_led;
        r_key       <= n_key;
        r_age       <= n_age;
        r_band      <= n_band;
        r_pos       <= n_pos;
        r_p1_led    <= r_led;
        r_p1_e      <= n_p1_e;
        r_e1_led    <= r_led;
        o_led_index <= 6'(r_e1_led);
        o_red       <= r_vld[r_e1_led] ? st_rdata[23:16] : 8'd0;
        o_green     <= r_vld[r_e1_led] ? st_rdata[15:8]  : 8'd0;
        o_blue      <= r_vld[r_e1_led] ? st_rdata[7:0]   : 8'd0;
        o_last      <= (r_e1_led == LW'(LED_N - 1));
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_vld    <= '0;
            r_p1_vld <= 1'b0;
            r_e1_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_vld    <= n_vld;
            r_p1_vld <= n_p1_vld;
            r_e1_vld <= n_e1_vld;
            o_valid  <= r_e1_vld;
        end
    end

    `KLR_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(RING_DEPTH), "ring count overflow")
    `KLR_ASSERT_IMP(a_wr_in_render, i_clk, i_rst_n, r_p1_vld, (r_state == S_SWEEP) || (r_state == S_AGE), "store write outside render")
    `KLR_ASSERT_NXT(a_emit_out, i_clk, i_rst_n, r_e1_vld, o_valid, "emit read lost")
endmodule
`default_nettype wire

// File: design/key_ripple_led_renderer_unit.sv
// top level of the key ripple led renderer
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  request   | start, busy, i_operation, i_key_column/row | in, busy out
//  result    | o_valid, o_led_index, o_red/green/blue,   | out
//            | o_last                                    |
//  config    | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
// a request is taken when start is high and busy is low; busy means the
// four-entry command queue is full
// key press: the engine writes the source ring; render: for each live source
// a load, a color store read-modify-write sweep over every led, then aging
// emit: one result per cycle, o_valid for one cycle each
// results cannot be stalled; the queue absorbs requests while a sweep runs
// synchronous active-low reset: ring empty, store reads zero, phase at -10
`default_nettype none
module key_ripple_led_renderer_unit import klr_pkg::*; #(
    parameter int RING_DEPTH = 32,
    parameter int ROW_STRIDE = 12,
    parameter int MAX_AGE    = 64,
    parameter int LED_COUNT  = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic       i_operation,
    input  wire logic [2:0] i_key_column,
    input  wire logic [3:0] i_key_row,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic       i_cfg_data,
    output logic            o_valid,
    output logic [5:0]      o_led_index,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue,
    output logic            o_last
);
    // config registers
    logic     r_red_en, r_green_en, r_blue_en, r_ripple_en;
    t_chan_en chan_en;

    logic     accept, push, full, cmd_vld, pop;
    t_cmd     push_cmd, head_cmd;

    assign accept  = start && !busy;
    assign busy    = full;
    assign chan_en = '{red: r_red_en, green: r_green_en, blue: r_blue_en};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_en    <= 1'b0;
            r_green_en  <= 1'b1;
            r_blue_en   <= 1'b1;
            r_ripple_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RED:    r_red_en    <= i_cfg_data;
                REG_GREEN:  r_green_en  <= i_cfg_data;
                REG_BLUE:   r_blue_en   <= i_cfg_data;
                REG_RIPPLE: r_ripple_en <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // decode: press, render or emit; other operation requests only step the phase
    klr_front #(.ROW_STRIDE(ROW_STRIDE)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_key_column(i_key_column),
        .i_key_row   (i_key_row),
        .i_ripple_en (r_ripple_en),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    klr_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_vld  (cmd_vld),
        .o_cmd  (head_cmd),
        .o_full (full)
    );

    // engine: ring updates, render sweeps and frame emission
    klr_back #(
        .RING_DEPTH(RING_DEPTH),
        .MAX_AGE   (MAX_AGE),
        .LED_COUNT (LED_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (head_cmd),
        .o_cmd_pop  (pop),
        .i_en       (chan_en),
        .o_valid    (o_valid),
        .o_led_index(o_led_index),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_last     (o_last)
    );
endmodule
`default_nettype wire
